FILE: rtl/pts_pkg.sv
// Shared types and codes for the periodic task table scheduler.
package pts_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_DELETE   = 3'd1,
    OP_SUSPEND  = 3'd2,
    OP_RESUME   = 3'd3,
    OP_TICK     = 3'd4,
    OP_DISPATCH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_TICK  = 2'd1,
    S_FLUSH = 2'd2
  } state_t;

endpackage

FILE: rtl/pts_slot_ram.sv
// Period and countdown storage: one write port, one registered read port.
module pts_slot_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/periodic_task_table_scheduler.sv
// Periodic task table scheduler: slot flags in flops, period/countdown in a RAM.
// Add, delete, suspend, resume, dispatch: result strobe in the cycle after acceptance.
// Tick: the RAM is swept one slot a cycle, read then write back, then a flush state
// follows; the result is registered from the flush state; busy is high until then.
// Sustained rate: one beat per cycle for non-tick operations; none during a tick.
// Synchronous reset clears all slot flags and the scan position; results cannot be stalled.
module periodic_task_table_scheduler #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [3:0]  task_index,
  input  logic [15:0] period,
  input  logic [15:0] start_delay,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  slot_index,
  output logic        one_shot_removed
);

  import pts_pkg::*;

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int DATA_W = 2 * TIME_BITS;

  function automatic logic [IDX_W-1:0] first_idx(input logic [MAX_TASKS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = MAX_TASKS - 1; k >= 0; k--) begin
      if (v[k]) r = IDX_W'(k);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [MAX_TASKS-1:0] used, active, ready, one_shot;
  logic [IDX_W-1:0]     scan_position;
  logic [IDX_W-1:0]     cnt;
  logic                 wb_valid;
  logic [IDX_W-1:0]     wb_idx;

  logic                 accept;
  op_t                  op;
  logic                 idx_ok;
  logic [IDX_W-1:0]     idx;
  logic [MAX_TASKS-1:0] free_vec, cand, cand_hi;
  logic                 full, found;
  logic [IDX_W-1:0]     free_idx, pick;
  logic [TIME_BITS-1:0] per_t, dly_t;

  status_t              res_status;
  logic [3:0]           res_slot;
  logic                 res_removed;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0] rd_per, rd_cd, cd_new;
  logic                 wb_live, wb_fire;

  assign accept   = start && !busy;
  assign op       = op_t'(operation);
  assign idx_ok   = {1'b0, task_index} < 5'(MAX_TASKS);
  assign idx      = task_index[IDX_W-1:0];
  assign per_t    = TIME_BITS'(period);
  assign dly_t    = TIME_BITS'(start_delay);

  assign free_vec = ~used;
  assign full     = ~|free_vec;
  assign free_idx = first_idx(free_vec);

  always_comb begin
    cand = used & active & ready;
    for (int k = 0; k < MAX_TASKS; k++) begin
      cand_hi[k] = cand[k] && (IDX_W'(k) >= scan_position);
    end
  end

  assign found = |cand;
  assign pick  = (|cand_hi) ? first_idx(cand_hi) : first_idx(cand);

  always_comb begin
    res_status  = ST_OK;
    res_slot    = 4'd0;
    res_removed = 1'b0;
    case (op)
      OP_ADD: begin
        if (full) begin
          res_status = ST_ERROR;
          res_slot   = 4'(MAX_TASKS);
        end else begin
          res_slot = 4'(free_idx);
        end
      end
      OP_DELETE, OP_SUSPEND, OP_RESUME: begin
        if (!idx_ok) res_status = ST_ERROR;
      end
      OP_TICK: begin
        res_status = ST_OK;
      end
      OP_DISPATCH: begin
        if (found) begin
          res_slot    = 4'(pick);
          res_removed = one_shot[pick];
        end else begin
          res_status = ST_NONE;
        end
      end
      default: begin
        res_status = ST_ERROR;
      end
    endcase
  end

  // tick write-back: reload on zero, then decrement
  assign rd_per  = ram_rdata[DATA_W-1:TIME_BITS];
  assign rd_cd   = ram_rdata[TIME_BITS-1:0];
  assign cd_new  = ((rd_cd == '0) ? rd_per : rd_cd) - TIME_BITS'(1);
  assign wb_live = used[wb_idx] && active[wb_idx];
  assign wb_fire = wb_valid && wb_live;

  always_comb begin
    if (wb_fire) begin
      ram_we    = 1'b1;
      ram_waddr = wb_idx;
      ram_wdata = {rd_per, cd_new};
    end else begin
      ram_we    = accept && (op == OP_ADD) && !full;
      ram_waddr = free_idx;
      ram_wdata = {per_t, dly_t};
    end
  end

  pts_slot_ram #(
    .DEPTH  (MAX_TASKS),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && (op == OP_TICK)) state_next = S_TICK;
      S_TICK:  if (cnt == IDX_W'(MAX_TASKS - 1)) state_next = S_FLUSH;
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE:  busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wb_valid <= (state == S_TICK);
      wb_idx   <= cnt;
      if (state == S_TICK) cnt <= (cnt == IDX_W'(MAX_TASKS - 1)) ? '0 : cnt + IDX_W'(1);
      else                 cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      active        <= '0;
      ready         <= '0;
      one_shot      <= '0;
      scan_position <= '0;
    end else begin
      if (wb_fire && (rd_cd == '0)) ready[wb_idx] <= 1'b1;
      if (accept) begin
        case (op)
          OP_ADD: begin
            if (!full) begin
              used[free_idx]     <= 1'b1;
              active[free_idx]   <= 1'b1;
              ready[free_idx]    <= 1'b0;
              one_shot[free_idx] <= (per_t == '0);
            end
          end
          OP_DELETE: begin
            if (idx_ok) begin
              used[idx]   <= 1'b0;
              active[idx] <= 1'b0;
              ready[idx]  <= 1'b0;
            end
          end
          OP_SUSPEND, OP_RESUME: begin
            if (idx_ok) active[idx] <= (op == OP_RESUME);
          end
          OP_DISPATCH: begin
            if (found) begin
              ready[pick]   <= 1'b0;
              scan_position <= (pick == IDX_W'(MAX_TASKS - 1)) ? '0 : pick + IDX_W'(1);
              if (one_shot[pick]) begin
                used[pick]   <= 1'b0;
                active[pick] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (op != OP_TICK)) || (state == S_FLUSH);
    end
    if (state == S_FLUSH) begin
      status           <= ST_OK;
      slot_index       <= 4'd0;
      one_shot_removed <= 1'b0;
    end else begin
      status           <= res_status;
      slot_index       <= res_slot;
      one_shot_removed <= res_removed;
    end
  end

  a_beat_next: assert property (@(posedge clk) disable iff (rst)
    (accept && (op != OP_TICK)) |=> done)
    else $error("non-tick beat without result");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_TICK)) |=> (busy && !done))
    else $error("tick beat did not hold busy");

  a_no_done_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |-> !done)
    else $error("result during tick sweep");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NONE)) |-> ((slot_index == 4'd0) && !one_shot_removed))
    else $error("empty dispatch with payload");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (done && one_shot_removed) |-> (status == ST_OK))
    else $error("one-shot removal with error status");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the periodic task table scheduler.
module tb;
  import pts_pkg::*;

  localparam int NSLOT = 8;
  localparam int TICK_LAT = NSLOT + 2;
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
  localparam int IDLE_PCT [4] = '{0, 68, 0, 11};

  typedef struct packed {
    status_t    st;
    logic [3:0] slot;
    logic       removed;
  } sched_out_t;

  class sched_scoreboard;
    bit         used      [NSLOT];
    bit [15:0]  reload    [NSLOT];
    bit [15:0]  countdown [NSLOT];
    bit         active    [NSLOT];
    bit         ready     [NSLOT];
    bit [2:0]   scan_pos;
    sched_out_t pending [$];
    int         errors;

    function void drop_slot(int k);
      used[k] = 1'b0;
      reload[k] = '0;
      countdown[k] = '0;
      active[k] = 1'b0;
      ready[k] = 1'b0;
    endfunction

    function void note_input(logic [2:0] op, logic [3:0] idx, logic [15:0] per,
                             logic [15:0] dly);
      sched_out_t r;
      int s;
      bit found;
      r.st = ST_OK;
      r.slot = '0;
      r.removed = 1'b0;
      found = 1'b0;
      case (op)
        OP_ADD: begin
          r.st = ST_ERROR;
          r.slot = 4'(NSLOT);
          for (int k = 0; k < NSLOT; k++) begin
            if (!found && !used[k]) begin
              found = 1'b1;
              used[k] = 1'b1;
              reload[k] = per;
              countdown[k] = dly;
              active[k] = 1'b1;
              ready[k] = 1'b0;
              r.st = ST_OK;
              r.slot = 4'(k);
            end
          end
        end
        OP_DELETE, OP_SUSPEND, OP_RESUME: begin
          if (idx >= NSLOT) r.st = ST_ERROR;
          else if (op == OP_DELETE) drop_slot(int'(idx));
          else active[int'(idx)] = (op == OP_RESUME);
        end
        OP_TICK: begin
          for (int k = 0; k < NSLOT; k++) begin
            if (used[k] && active[k]) begin
              if (countdown[k] == 0) begin
                ready[k] = 1'b1;
                countdown[k] = reload[k];
              end
              countdown[k] = countdown[k] - 16'd1;
            end
          end
        end
        OP_DISPATCH: begin
          r.st = ST_NONE;
          for (int k = 0; k < NSLOT; k++) begin
            s = (scan_pos + k) % NSLOT;
            if (!found && used[s] && active[s] && ready[s]) begin
              found = 1'b1;
              ready[s] = 1'b0;
              if (reload[s] == 0) begin
                drop_slot(s);
                r.removed = 1'b1;
              end
              r.st = ST_OK;
              r.slot = 4'(s);
              scan_pos = 3'((s + 1) % NSLOT);
            end
          end
        end
        default: r.st = ST_ERROR;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [3:0] sl, logic rm);
      sched_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d slot %0d removed %0d", st, sl, rm);
        return;
      end
      e = pending.pop_front();
      if (e.st !== st || e.slot !== sl || e.removed !== rm) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp status %0d slot %0d removed %0d, got %0d %0d %0d",
                   e.st, e.slot, e.removed, st, sl, rm);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  operation;
  logic [3:0]  task_index;
  logic [15:0] period;
  logic [15:0] start_delay;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  slot_index;
  logic        one_shot_removed;

  int idle_pct;
  sched_scoreboard sb = new;

  periodic_task_table_scheduler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .task_index(task_index),
    .period(period),
    .start_delay(start_delay),
    .done(done),
    .status(status),
    .slot_index(slot_index),
    .one_shot_removed(one_shot_removed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_input(operation, task_index, period, start_delay);
    if (!rst && done) sb.check_result(status, slot_index, one_shot_removed);
  end

  // entered just after a falling edge; returns just after the falling edge past the beat
  task automatic send_beat(logic [2:0] op, logic [3:0] idx, logic [15:0] per,
                           logic [15:0] dly);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    operation = op;
    task_index = idx;
    period = per;
    start_delay = dly;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic rand_beat();
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [15:0] per;
    logic [15:0] dly;
    int r;
    r = $urandom_range(99);
    if (r < 16) op = OP_ADD;
    else if (r < 28) op = OP_DELETE;
    else if (r < 36) op = OP_SUSPEND;
    else if (r < 46) op = OP_RESUME;
    else if (r < 72) op = OP_TICK;
    else if (r < 97) op = OP_DISPATCH;
    else op = ($urandom_range(1) == 0) ? OP_BAD_LO : OP_BAD_HI;
    idx = ($urandom_range(99) < 85) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 8));
    per = ($urandom_range(99) < 70) ? 16'($urandom_range(6)) : 16'($urandom);
    dly = ($urandom_range(99) < 75) ? 16'($urandom_range(4)) : 16'($urandom);
    send_beat(op, idx, per, dly);
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_ADD;
    task_index = '0;
    period = '0;
    start_delay = '0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table, extremes, bad indexes and codes, one-shot removal, full table
    send_beat(OP_DISPATCH, 4'd0, 16'd0, 16'd0);
    send_beat(OP_TICK, 4'd0, 16'd0, 16'd0);
    send_beat(OP_ADD, 4'd0, 16'd0, 16'd0);
    send_beat(OP_ADD, 4'd0, 16'hFFFF, 16'hFFFF);
    send_beat(OP_ADD, 4'd0, 16'd1, 16'd0);
    send_beat(OP_SUSPEND, 4'd5, 16'd0, 16'd0);
    send_beat(OP_RESUME, 4'd5, 16'd0, 16'd0);
    send_beat(OP_DELETE, 4'd8, 16'd0, 16'd0);
    send_beat(OP_SUSPEND, 4'd15, 16'd0, 16'd0);
    send_beat(OP_RESUME, 4'd9, 16'd0, 16'd0);
    send_beat(OP_BAD_LO, 4'd0, 16'd0, 16'd0);
    send_beat(OP_BAD_HI, 4'd0, 16'd0, 16'd0);
    send_beat(OP_TICK, 4'd0, 16'd0, 16'd0);
    send_beat(OP_DISPATCH, 4'd0, 16'd0, 16'd0);
    send_beat(OP_DISPATCH, 4'd0, 16'd0, 16'd0);
    send_beat(OP_SUSPEND, 4'd2, 16'd0, 16'd0);
    send_beat(OP_TICK, 4'd0, 16'd0, 16'd0);
    send_beat(OP_RESUME, 4'd2, 16'd0, 16'd0);
    send_beat(OP_ADD, 4'd0, 16'hAAAA, 16'h5555);
    send_beat(OP_ADD, 4'd0, 16'h5555, 16'hAAAA);
    repeat (5) send_beat(OP_ADD, 4'd0, 16'd2, 16'd1);
    send_beat(OP_DELETE, 4'd1, 16'd0, 16'd0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = IDLE_PCT[p];
      repeat (210) rand_beat();
    end
    start = 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TICK_LAT + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
